// File: rtl/sorted_set_union_merge_core_assert.svh
// Assertion helpers for the sorted set union merge core.
// Each macro checks an implication on the rising edge of clk_i, off while in reset.
`ifndef SORTED_SET_UNION_MERGE_CORE_ASSERT_SVH
`define SORTED_SET_UNION_MERGE_CORE_ASSERT_SVH

`ifndef SYNTH
`define SSUM_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);
`define SSUM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);
`else
`define SSUM_ASSERT_SAME(lbl, ant, cons, msg)
`define SSUM_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

// File: rtl/ssum_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssum_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned VAL_W = 31;

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_RUN         = 2'd2
  } mode_e;

endpackage
`default_nettype wire

// File: rtl/ssum_list_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module ssum_list_mem
  import ssum_pkg::*;
#(
  parameter int unsigned DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/sorted_set_union_merge_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Loads two ascending lists and streams their sorted union. A load transaction
// (mode 0 or 1) leaves busy_o low. A run transaction (mode 2) holds busy_o high
// until the union is walked, then the lists and the drop flag clear: one shared
// comparator walks both list memories, each read once per cycle, and picks one
// union element per cycle. Each result is registered and appears in the cycle
// after it is picked, one per cycle on strobe_o, the last one marked by last_o;
// an empty union gives a single result with valid_res_o low. The receiver cannot
// stall, so every strobed result must be taken as it comes.
module sorted_set_union_merge_core
  import ssum_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [VAL_W-1:0] element_i,
  output logic                  strobe_o,
  output logic      [VAL_W-1:0] union_value_o,
  output logic                  valid_res_o,
  output logic                  last_o,
  output logic                  overflow_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]    ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic             drop_q, drop_d;
  logic             strobe_q, strobe_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             valid_q, valid_d;
  logic             last_q, last_d;
  logic             ovf_q, ovf_d;

  logic             accept;
  logic             we_a, we_b;
  logic [VAL_W-1:0] head_a, head_b;
  logic             has_a, has_b, take_a, take_b, done;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  ssum_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(cnt_a_q[AW-1:0]),
    .wdata_i(element_i),
    .raddr_i(ptr_a_d[AW-1:0]),
    .rdata_o(head_a)
  );

  ssum_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(cnt_b_q[AW-1:0]),
    .wdata_i(element_i),
    .raddr_i(ptr_b_d[AW-1:0]),
    .rdata_o(head_b)
  );

  // shared compare: pick the smaller head, both on a tie
  assign has_a  = (ptr_a_q < cnt_a_q);
  assign has_b  = (ptr_b_q < cnt_b_q);
  assign take_a = has_a && (!has_b || (head_a <= head_b));
  assign take_b = has_b && (!has_a || (head_b <= head_a));

  always_comb begin
    state_d  = state_q;
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    ptr_a_d  = '0;
    ptr_b_d  = '0;
    drop_d   = drop_q;
    strobe_d = 1'b0;
    value_d  = value_q;
    valid_d  = valid_q;
    last_d   = last_q;
    ovf_d    = ovf_q;
    we_a     = 1'b0;
    we_b     = 1'b0;
    done     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_LOAD_FIRST: begin
              if (cnt_a_q < FULL) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            MODE_LOAD_SECOND: begin
              if (cnt_b_q < FULL) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + CW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            MODE_RUN: begin
              state_d = ST_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        ptr_a_d  = ptr_a_q + CW'(take_a);
        ptr_b_d  = ptr_b_q + CW'(take_b);
        done     = !((ptr_a_d < cnt_a_q) || (ptr_b_d < cnt_b_q));
        strobe_d = 1'b1;
        value_d  = take_a ? head_a : (take_b ? head_b : '0);
        valid_d  = has_a || has_b;
        last_d   = done;
        ovf_d    = drop_q;
        if (done) begin
          state_d = ST_IDLE;
          cnt_a_d = '0;
          cnt_b_d = '0;
          drop_d  = 1'b0;
          ptr_a_d = '0;
          ptr_b_d = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      ptr_a_q  <= '0;
      ptr_b_q  <= '0;
      drop_q   <= 1'b0;
      strobe_q <= 1'b0;
      value_q  <= '0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      ptr_a_q  <= ptr_a_d;
      ptr_b_q  <= ptr_b_d;
      drop_q   <= drop_d;
      strobe_q <= strobe_d;
      value_q  <= value_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
      ovf_q    <= ovf_d;
    end
  end

  assign strobe_o      = strobe_q;
  assign union_value_o = value_q;
  assign valid_res_o   = valid_q;
  assign last_o        = last_q;
  assign overflow_o    = ovf_q;

`include "sorted_set_union_merge_core_assert.svh"

  `SSUM_ASSERT_SAME(a_empty_is_last, strobe_o && !valid_res_o, last_o,
    "empty union result without last marker")
  `SSUM_ASSERT_NEXT(a_last_ends_run, strobe_o && last_o, !strobe_o,
    "result strobed after the last one of a run")
  `SSUM_ASSERT_NEXT(a_run_goes_busy, accept && (mode_i == MODE_RUN), busy_o,
    "run transaction did not raise busy")
  `SSUM_ASSERT_SAME(a_ptr_in_range, state_q == ST_MERGE,
    (ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q), "merge pointer past list fill")
  `SSUM_ASSERT_SAME(a_cnt_bound, 1'b1, (cnt_a_q <= FULL) && (cnt_b_q <= FULL),
    "list count above capacity")

endmodule
`default_nettype wire

// File: tb/tb_sorted_set_union_merge_core.sv
`timescale 1ns / 1ps
module tb_sorted_set_union_merge_core;
  import ssum_pkg::*;

  localparam int unsigned DEPTH = LIST_DEPTH_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned RANDOM_ITEMS = 160;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]       mode;
    logic [VAL_W-1:0] element;
    bit               drain;
    int unsigned      gap_pct;
  } merge_cmd_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             valid;
    logic             last;
    logic             overflow;
  } union_elem_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic [1:0]       mode_i = MODE_LOAD_FIRST;
  logic [VAL_W-1:0] element_i = '0;
  logic             busy_o;
  logic             strobe_o;
  logic [VAL_W-1:0] union_value_o;
  logic             valid_res_o;
  logic             last_o;
  logic             overflow_o;

  merge_cmd_t  cmd_q[$];
  union_elem_t union_q[$];
  merge_cmd_t  cur_cmd;
  int unsigned cur_gap = 0;

  logic [VAL_W-1:0] first_set[DEPTH];
  logic [VAL_W-1:0] second_set[DEPTH];
  int unsigned      first_cnt = 0;
  int unsigned      second_cnt = 0;
  bit               drop_seen = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  sorted_set_union_merge_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .element_i    (element_i),
    .strobe_o     (strobe_o),
    .union_value_o(union_value_o),
    .valid_res_o  (valid_res_o),
    .last_o       (last_o),
    .overflow_o   (overflow_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void note_failure(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void push_cmd(logic [1:0] m, logic [VAL_W-1:0] e, bit drain);
    merge_cmd_t c;
    c.mode = m;
    c.element = e;
    c.drain = drain;
    c.gap_pct = cur_gap;
    cmd_q = {cmd_q, c};
  endfunction

  // Walk both sets and queue the union elements this run must produce.
  function automatic void merge_union();
    logic [VAL_W-1:0] vals[$];
    union_elem_t      r;
    int unsigned      ia = 0;
    int unsigned      ib = 0;
    while (ia < first_cnt && ib < second_cnt) begin
      if (first_set[ia] < second_set[ib]) begin
        vals = {vals, first_set[ia]};
        ia++;
      end else if (first_set[ia] > second_set[ib]) begin
        vals = {vals, second_set[ib]};
        ib++;
      end else begin
        vals = {vals, first_set[ia]};
        ia++;
        ib++;
      end
    end
    while (ia < first_cnt) begin
      vals = {vals, first_set[ia]};
      ia++;
    end
    while (ib < second_cnt) begin
      vals = {vals, second_set[ib]};
      ib++;
    end
    r.overflow = drop_seen;
    if (vals.size() == 0) begin
      r.value = '0;
      r.valid = 1'b0;
      r.last = 1'b1;
      union_q = {union_q, r};
    end else begin
      foreach (vals[i]) begin
        r.value = vals[i];
        r.valid = 1'b1;
        r.last = (i == vals.size() - 1);
        union_q = {union_q, r};
      end
    end
    first_cnt = 0;
    second_cnt = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void apply_cmd(merge_cmd_t c);
    case (c.mode)
      MODE_LOAD_FIRST: begin
        if (first_cnt < DEPTH) begin
          first_set[first_cnt] = c.element;
          first_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      MODE_LOAD_SECOND: begin
        if (second_cnt < DEPTH) begin
          second_set[second_cnt] = c.element;
          second_cnt++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      MODE_RUN: merge_union();
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : driver
    bit raise;
    raise = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) apply_cmd(cur_cmd);
      if (start_i && busy_o) begin
        raise = 1'b1;
      end else if (cmd_q.size() != 0) begin
        if (cmd_q[0].drain) begin
          // hold off until every pending union element has come out
          if (union_q.size() == 0) void'(cmd_q.pop_front());
        end else if ($urandom_range(99) >= cmd_q[0].gap_pct) begin
          cur_cmd = cmd_q.pop_front();
          raise = 1'b1;
          mode_i <= cur_cmd.mode;
          element_i <= cur_cmd.element;
        end
      end
    end
    start_i <= raise;
  end

  always @(posedge clk_i) begin : monitor
    union_elem_t exp_r;
    if (rst_ni && strobe_o) begin
      if (union_q.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0h valid=%0b last=%0b ovf=%0b",
                               union_value_o, valid_res_o, last_o, overflow_o));
      end else begin
        exp_r = union_q.pop_front();
        if (union_value_o !== exp_r.value || valid_res_o !== exp_r.valid ||
            last_o !== exp_r.last || overflow_o !== exp_r.overflow)
          note_failure($sformatf({"exp value=%0h valid=%0b last=%0b ovf=%0b, ",
                                  "got value=%0h valid=%0b last=%0b ovf=%0b"},
                                 exp_r.value, exp_r.valid, exp_r.last, exp_r.overflow,
                                 union_value_o, valid_res_o, last_o, overflow_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VAL_W-1:0] set_a[$];
    logic [VAL_W-1:0] set_b[$];
    logic [VAL_W-1:0] val;
    logic [31:0]      sum;
    int unsigned      loaded;
    int unsigned      na;
    int unsigned      nb;
    int unsigned      span;
    bit               ascending;
    bit               pick_a;

    // directed: empty union, equal heads, extremes, one-sided, unordered, duplicates
    cur_gap = 0;
    push_cmd(MODE_RUN, '0, 1'b0);
    push_cmd(MODE_LOAD_FIRST, '0, 1'b0);
    push_cmd(MODE_LOAD_SECOND, 31'd5, 1'b0);
    push_cmd(MODE_LOAD_FIRST, 31'd5, 1'b0);
    push_cmd(MODE_LOAD_SECOND, 31'd7, 1'b0);
    push_cmd(MODE_LOAD_FIRST, VAL_MAX, 1'b0);
    push_cmd(MODE_RUN, VAL_MAX, 1'b0);
    push_cmd(MODE_UNUSED, VAL_MAX, 1'b0);
    push_cmd(MODE_LOAD_SECOND, 31'd3, 1'b0);
    push_cmd(MODE_RUN, '0, 1'b0);
    push_cmd(MODE_LOAD_FIRST, 31'd9, 1'b0);
    push_cmd(MODE_LOAD_FIRST, 31'd2, 1'b0);
    push_cmd(MODE_LOAD_SECOND, 31'd4, 1'b0);
    push_cmd(MODE_LOAD_SECOND, VAL_MAX, 1'b0);
    push_cmd(MODE_RUN, '0, 1'b0);
    push_cmd(MODE_LOAD_FIRST, 31'd1, 1'b0);
    push_cmd(MODE_LOAD_FIRST, 31'd1, 1'b0);
    push_cmd(MODE_LOAD_SECOND, 31'd1, 1'b0);
    push_cmd(MODE_RUN, '0, 1'b0);
    push_cmd(MODE_UNUSED, '0, 1'b1);

    loaded = 0;
    while (loaded < RANDOM_ITEMS) begin
      case (loaded * 4 / RANDOM_ITEMS)
        0: cur_gap = 0;
        1: cur_gap = 51;
        2: cur_gap = 0;
        default: cur_gap = 6;
      endcase
      if ($urandom_range(9) == 0) begin
        na = $urandom_range(36, 20);
        nb = $urandom_range(36, 20);
      end else begin
        na = $urandom_range(6);
        nb = $urandom_range(6);
      end
      ascending = ($urandom_range(4) != 0);
      case ($urandom_range(2))
        0: span = 2;
        1: span = 1000;
        default: span = 32'h0100_0000;
      endcase
      set_a.delete();
      set_b.delete();
      for (int s = 0; s < 2; s++) begin
        // the second set often reuses a value of the first as its base so equal heads show up often
        if (s == 0 || $urandom_range(1) == 0)
          val = $urandom_range(2) == 0 ? VAL_W'(VAL_MAX - $urandom_range(40))
                                       : VAL_W'($urandom_range(1000));
        for (int i = 0; i < (s == 0 ? na : nb); i++) begin
          if (ascending) begin
            sum = {1'b0, val} + $urandom_range(span);
            val = sum[31] ? VAL_MAX : sum[VAL_W-1:0];
          end else begin
            val = VAL_W'($urandom);
          end
          if (s == 0) set_a = {set_a, val};
          else set_b = {set_b, val};
        end
        if (s == 0 && $urandom_range(1) == 0) val = set_a.size() != 0 ? set_a[0] : val;
      end
      while (set_a.size() != 0 || set_b.size() != 0) begin
        pick_a = (set_b.size() == 0) || (set_a.size() != 0 && $urandom_range(1) == 0);
        if (pick_a) push_cmd(MODE_LOAD_FIRST, set_a.pop_front(), 1'b0);
        else push_cmd(MODE_LOAD_SECOND, set_b.pop_front(), 1'b0);
        if ($urandom_range(19) == 0) push_cmd(MODE_UNUSED, VAL_W'($urandom), 1'b0);
      end
      push_cmd(MODE_RUN, VAL_W'($urandom), 1'b0);
      if ($urandom_range(5) == 0) push_cmd(MODE_UNUSED, '0, 1'b1);
      loaded += na + nb + 1;
    end

    while (cmd_q.size() != 0 || start_i || union_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (union_q.size() != 0) note_failure("union elements still pending at end");
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
